>>> rtl/box_blur_3x3_stream_top_assert.svh
// assertion macros for the box blur block
`ifndef BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box blur assertion failed");

// next-cycle implication, masked during reset
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box blur assertion failed");

`endif

>>> rtl/bb3_pkg.sv
package bb3_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 13;
  localparam int SUM_W        = 12;
  localparam int MULT_W       = 25;
  localparam int MAX_LINE_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;
  localparam int MIN_DIM      = 3;

  // register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PADDED_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PADDED_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 13'd2050;

  // fixed-point 1/9 with round to nearest
  localparam logic [12:0] RECIP9_MUL = 13'd7282;
  localparam logic [MULT_W-1:0] RECIP9_RND = 25'd32768;
  localparam int RECIP9_SHIFT = 16;

endpackage

>>> rtl/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/box_blur_3x3_stream_top.sv
// 3x3 box blur over a padded image streamed in raster order, one pixel word
// per clock. The line-buffer read for a pixel happens at the edge that
// accepts it; the window shift, nine-way sum and scaling by 1/9 follow in
// registered stages (stage 1 read data, stage 2 window, stage 3 sum, output
// register), and the block keeps one pixel a clock going as long as
// the output is not stalled. A result appears only where the 3x3 window lies
// fully inside the padded frame (column and row at least 2), so a frame of
// W x H padded pixels gives (W-2) x (H-2) results; row_end marks the last
// result of each row and frame_end the last of the frame. The result is the
// mean of the nine pixels rounded to nearest. Both rows above are kept in one
// dual-port RAM, two pixels per entry, MAX_LINE entries deep; its contents are
// not cleared; stale entries are read only in rows 0 and 1, giving no result.
// padded_width and padded_height saturate to [3, MAX_LINE] and [3, MAX_ROWS];
// write them only while the block is idle. frame_start restarts the position
// at column 0, row 0; after the last pixel of a frame the position wraps by
// itself.
module box_blur_3x3_stream_top #(
  parameter int MAX_LINE = bb3_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = bb3_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bb3_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_frame_start,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb3_pkg::PIX_W-1:0]     out_blurred,
  output logic                          out_row_end,
  output logic                          out_frame_end,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PW    = bb3_pkg::PIX_W;
  localparam int CW    = bb3_pkg::CFG_W;
  localparam int COL_W = $clog2(MAX_LINE);
  localparam int ROW_W = $clog2(MAX_ROWS);
  // compare width for dimensions, wide enough for the register and the maxima
  localparam int LW    = ($clog2(MAX_LINE + 1) > CW) ? $clog2(MAX_LINE + 1) : CW;
  localparam int HW    = ($clog2(MAX_ROWS + 1) > CW) ? $clog2(MAX_ROWS + 1) : CW;
  localparam int SW    = bb3_pkg::SUM_W;
  localparam int MW    = bb3_pkg::MULT_W;

  // configuration registers
  logic [CW-1:0] cfg_width_r;
  logic [CW-1:0] cfg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= bb3_pkg::DIM_RESET;
      cfg_height_r <= bb3_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bb3_pkg::REG_PADDED_WIDTH:  cfg_width_r  <= cfg_data;
        bb3_pkg::REG_PADDED_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated dimensions
  logic [LW-1:0] width_ext, width_eff;
  logic [HW-1:0] height_ext, height_eff;

  always_comb begin
    width_ext  = LW'(cfg_width_r);
    height_ext = HW'(cfg_height_r);
    priority if (width_ext < LW'(bb3_pkg::MIN_DIM)) width_eff = LW'(bb3_pkg::MIN_DIM);
    else if (width_ext > LW'(MAX_LINE))             width_eff = LW'(MAX_LINE);
    else                                            width_eff = width_ext;
    priority if (height_ext < HW'(bb3_pkg::MIN_DIM)) height_eff = HW'(bb3_pkg::MIN_DIM);
    else if (height_ext > HW'(MAX_ROWS))             height_eff = HW'(MAX_ROWS);
    else                                             height_eff = height_ext;
  end

  // whole pipeline advances together whenever the output register is free
  logic en;
  logic in_acc;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  // ---------------------------------------------------------------- position
  logic [COL_W-1:0] col_r, col_cur, col_nxt;
  logic [ROW_W-1:0] row_r, row_cur, row_nxt;
  logic             last_col, last_row, emit;

  always_comb begin
    col_cur  = in_frame_start ? '0 : col_r;
    row_cur  = in_frame_start ? '0 : row_r;
    last_col = (LW'(col_cur) + LW'(1)) >= width_eff;
    last_row = (HW'(row_cur) + HW'(1)) >= height_eff;
    emit     = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------- stage 1: line-buffer read data
  // ram word: upper byte is two rows above, lower byte is the row above
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PW-1:0]    s1_px_r;
  logic             s1_emit_r, s1_row_end_r, s1_frame_end_r;
  logic [2*PW-1:0]  ram_rdata, up_word, ram_wdata;
  logic [PW-1:0]    up1, up2;
  logic             ram_we;
  // bypass for a pixel that reads the column written in the same cycle
  logic             fwd_hit_r;
  logic [2*PW-1:0]  fwd_data_r;

  assign up_word   = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign up1       = up_word[PW-1:0];
  assign up2       = up_word[2*PW-1:PW];
  assign ram_wdata = {up1, s1_px_r};
  assign ram_we    = en && s1_valid_r;

  bb3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      fwd_hit_r  <= in_valid && s1_valid_r && (s1_col_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col_r       <= col_cur;
      s1_row_r       <= row_cur;
      s1_px_r        <= in_pixel;
      s1_emit_r      <= emit;
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
      fwd_data_r     <= ram_wdata;
    end
  end

  // ---------------------------------------------------- stage 2: 3x3 window
  // window_r[r*3+c]: r = 0 oldest row, c = 0 oldest column
  logic [PW-1:0] window_r [9];
  logic          s2_valid_r, s2_row_end_r, s2_frame_end_r;

  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r*3]   <= window_r[r*3+1];
        window_r[r*3+1] <= window_r[r*3+2];
      end
      window_r[2] <= up2;
      window_r[5] <= up1;
      window_r[8] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row_end_r   <= s1_row_end_r;
      s2_frame_end_r <= s1_frame_end_r;
    end
  end

  // ------------------------------------------------------ stage 3: nine-way sum
  logic [SW-1:0] sum_nxt, sum_r;
  logic          s3_valid_r, s3_row_end_r, s3_frame_end_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      sum_nxt = sum_nxt + SW'(window_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r          <= sum_nxt;
      s3_row_end_r   <= s2_row_end_r;
      s3_frame_end_r <= s2_frame_end_r;
    end
  end

  // ---------------------------------------------- output: scale by 1/9, round
  logic [MW-1:0] scaled;
  logic [PW-1:0] blurred_r;
  logic          row_end_r, frame_end_r;

  assign scaled = MW'(sum_r) * MW'(bb3_pkg::RECIP9_MUL) + bb3_pkg::RECIP9_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blurred_r   <= scaled[bb3_pkg::RECIP9_SHIFT +: PW];
      row_end_r   <= s3_row_end_r;
      frame_end_r <= s3_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blurred   = blurred_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

  // ------------------------------------------------------------- assertions
`include "box_blur_3x3_stream_top_assert.svh"

  // a frame start word lands in stage 1 at the origin
  `BB3_ASSERT_NEXT(a_frame_start_origin, clk, rst_n, in_acc && in_frame_start, s1_col_r == '0 && s1_row_r == '0)
  // frame end only ever comes with a row end
  `BB3_ASSERT_NOW(a_frame_end_row_end, clk, rst_n, out_valid_r && out_frame_end, out_row_end)
  // a pending sum is kept while the output is stalled
  `BB3_ASSERT_NEXT(a_sum_held, clk, rst_n, s3_valid_r && !en, s3_valid_r && $stable(sum_r))
  // the bypass fires only for a word that is really in stage 1
  `BB3_ASSERT_NOW(a_fwd_needs_word, clk, rst_n, fwd_hit_r, s1_valid_r)

endmodule

>>> tb/bb3_blur_checker.sv
// watches both channels and the register port, predicts each blurred word
// and compares it with what the block delivers
module bb3_blur_checker
  import bb3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 in_frame_start,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_blurred,
  input  logic                 out_row_end,
  input  logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   awaited
);

  localparam int unsigned LINE_DEPTH = MAX_LINE_DEF;
  localparam int unsigned ROW_LIMIT  = MAX_ROWS_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             row_end;
    logic             frame_end;
  } blur_word_t;

  blur_word_t       blur_due[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] row_above [LINE_DEPTH];
  logic [PIX_W-1:0] row_two_above [LINE_DEPTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int               bad_count = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic blur_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      sum;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    logic             last_col;
    logic             last_row;
    blur_word_t       word;
    w = clamp_dim(width_reg, LINE_DEPTH);
    h = clamp_dim(height_reg, ROW_LIMIT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    up1 = '0;
    up2 = '0;
    if (col_pos < LINE_DEPTH) begin
      up1 = row_above[col_pos];
      up2 = row_two_above[col_pos];
      row_two_above[col_pos] = up1;
      row_above[col_pos] = pix;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = pix;
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    if (col_pos >= 2 && row_pos >= 2) begin
      sum = 0;
      foreach (win[i]) sum += win[i];
      // nearest integer to sum/9, never a tie
      word.blurred   = PIX_W'((2 * sum + 9) / 18);
      word.row_end   = last_col;
      word.frame_end = last_col && last_row;
      blur_due.push_back(word);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_word(input blur_word_t got);
    blur_word_t want;
    if (blur_due.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: result word with none expected: blurred %0d row_end %0b frame_end %0b",
                 $realtime, got.blurred, got.row_end, got.frame_end);
      return;
    end
    want = blur_due.pop_front();
    if (got.blurred !== want.blurred || got.row_end !== want.row_end ||
        got.frame_end !== want.frame_end) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: mismatch expected blurred %0d row_end %0b frame_end %0b, %s %0d %0b %0b",
                 $realtime, want.blurred, want.row_end, want.frame_end, "actual",
                 got.blurred, got.row_end, got.frame_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      col_pos    = 0;
      row_pos    = 0;
      foreach (win[i]) win[i] = '0;
      blur_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PADDED_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_PADDED_HEIGHT) height_reg = cfg_data;
      end
      if (in_valid && !in_stall) blur_pixel(in_pixel, in_frame_start);
      if (out_valid && !out_stall) check_word({out_blurred, out_row_end, out_frame_end});
    end
    mismatches <= bad_count;
    awaited    <= blur_due.size();
  end

endmodule

>>> tb/tb.sv
module tb;
  import bb3_pkg::*;

  // pixel content styles for a frame
  typedef enum int {MIX_ANY, MIX_EXTREME, MIX_BRIGHT, MIX_DARK} pixel_mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel;
  logic                 in_frame_start;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_blurred;
  logic                 out_row_end;
  logic                 out_frame_end;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int   mismatches;
  int   awaited;
  // high while neither side idles
  logic calm;
  int   words_sent = 0;

  box_blur_3x3_stream_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blurred    (out_blurred),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // prediction and comparison live beside the block
  bb3_blur_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blurred    (out_blurred),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  always #5 clk = ~clk;

  // receiver stalls at random with a chance of about 12 in a hundred, never while calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_t mix);
    case (mix)
      MIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      MIX_BRIGHT:  return 8'($urandom_range(255, 240));
      MIX_DARK:    return 8'($urandom_range(15));
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one pixel word, with random idle cycles ahead of it, and wait for the
  // handshake; valid stays high when the next word follows straight away
  task automatic send_word(input logic [PIX_W-1:0] pix, input logic fs);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // a run of pixels in raster order, frame_start on the first one if asked
  task automatic send_run(input int unsigned len, input logic fs, input pixel_mix_t mix);
    for (int unsigned i = 0; i < len; i++) send_word(pick_pixel(mix), fs && i == 0);
  endtask

  // stop sending, let every expected word come out, then cover the pipeline
  // depth so that pixels with no result have left the block too
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // both dimension registers on back-to-back cycles, block idle
  task automatic set_dims(input int unsigned w, input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PADDED_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_PADDED_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_height(input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PADDED_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned w_reg;
    int unsigned h_reg;
    int unsigned frames;
    int unsigned stop_at;
    int          phase;
    logic        restart;
    pixel_mix_t  mix;

    // every block input known from time zero
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel       <= '0;
    in_frame_start <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_PADDED_WIDTH;
    cfg_data       <= '0;
    calm           <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: registers below range saturate to the 3x3 minimum
    set_dims(0, 1);
    // all-bright frame gives the top sum, 255 out with both end flags
    for (int i = 0; i < 9; i++) send_word(8'hFF, i == 0);
    // a partial frame then frame_start restarts the position mid-frame;
    // the all-dark frame after it must come out as 0
    send_run(3, 1'b0, MIX_ANY);
    for (int i = 0; i < 9; i++) send_word(8'h00, i == 0);
    settle();

    // height lowered mid-frame: the current row past the new height becomes
    // the last one, then frames wrap by themselves at the new size
    set_dims(5, 9);
    send_run(30, 1'b1, MIX_ANY);
    settle();
    set_height(4);
    send_run(5, 1'b0, MIX_ANY);
    send_run(20, 1'b0, MIX_ANY);
    settle();

    // random phases of small frames; each phase starts a frame with
    // frame_start since the width may have changed; later frames either
    // wrap by themselves or restart, and a few are cut short
    stop_at = words_sent + 1000;
    phase   = 0;
    while (words_sent < stop_at) begin
      w_reg = $urandom_range(12, 3);
      h_reg = $urandom_range(10, 3);
      if ($urandom_range(9) == 0) w_reg = $urandom_range(2);
      if ($urandom_range(9) == 0) h_reg = $urandom_range(2);
      w = (w_reg < MIN_DIM) ? MIN_DIM : w_reg;
      h = (h_reg < MIN_DIM) ? MIN_DIM : h_reg;
      // one long stretch with no idling on either side
      calm <= (phase >= 4 && phase < 8);
      set_dims(w_reg, h_reg);
      frames  = $urandom_range(4, 1);
      restart = 1'b1;
      for (int unsigned f = 0; f < frames; f++) begin
        mix = pixel_mix_t'($urandom_range(3));
        if ($urandom_range(11) == 0) begin
          // broken frame, the next one has to restart
          send_run($urandom_range(w * h - 1, 1), 1'b1, mix);
          restart = 1'b1;
        end else begin
          send_run(w * h, restart || $urandom_range(1), mix);
          restart = 1'b0;
        end
      end
      settle();
      phase++;
    end
    calm <= 1'b0;

    // registers written past the maximum: a width that saturates to 4096
    // keeps the first row open, and a tall narrow frame never ends early
    set_dims(8191, 3);
    send_run(200, 1'b1, MIX_ANY);
    settle();
    set_dims(3, 8191);
    send_run(300, 1'b1, MIX_ANY);
    settle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, many times the slowest correct run
  initial begin
    #(4_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
